// ----- sv/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the MIDI track event parser
// Result word layout, event kind codes and default widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  // Width of the delta time field in a result word
  localparam int DELTA_OUT_W = 28;

  // Default width of the delta time accumulator
  localparam int DELTA_BITS_DEFAULT = 28;

  // Event kind codes
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_ONE_DATA = 2'd2;
  localparam logic [1:0] KIND_TWO_DATA = 2'd3;

  // Upper status nibbles with special handling
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_PROGRAM  = 4'hC;
  localparam logic [3:0] STAT_PRESSURE = 4'hD;

  // One decoded event
  typedef struct packed {
    logic [1:0]             kind;
    logic [3:0]             status_high;
    logic [3:0]             channel;
    logic [7:0]             first_data;
    logic [7:0]             second_data;
    logic [DELTA_OUT_W-1:0] delta_time;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/mtep_decode.sv -----
// ----------------------------------------------------------------------------
// mtep_decode: byte-wise event decoder
// Holds the parse state and turns each accepted byte into a state update and,
// when an event completes, one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtep_decode #(
  parameter int DELTA_BITS = mtep_pkg::DELTA_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              track_start,
  output logic                   push,
  output mtep_pkg::result_t      result
);

  // Parse phases
  localparam logic [1:0] PH_DELTA  = 2'd0;
  localparam logic [1:0] PH_STATUS = 2'd1;
  localparam logic [1:0] PH_FIRST  = 2'd2;
  localparam logic [1:0] PH_SECOND = 2'd3;

  logic [1:0]            phase, phase_next;
  logic [DELTA_BITS-1:0] acc, acc_next;
  logic [7:0]            run_status, run_status_next;
  logic [7:0]            held, held_next;

  // State as seen by this byte: a track start clears it first
  logic [1:0]            phase_eff;
  logic [DELTA_BITS-1:0] acc_eff;
  logic [7:0]            rs_eff;
  logic [7:0]            held_eff;
  logic                  one_data;
  logic                  emit;
  logic [7:0]            emit_first, emit_second;
  logic [1:0]            kind;

  always_comb begin
    phase_eff = track_start ? PH_DELTA : phase;
    acc_eff   = track_start ? '0 : acc;
    rs_eff    = track_start ? 8'h00 : run_status;
    held_eff  = track_start ? 8'h00 : held;
  end

  // Kind of the status in force
  always_comb begin
    case (rs_eff[7:4])
      mtep_pkg::STAT_NOTE_ON:  kind = mtep_pkg::KIND_NOTE_ON;
      mtep_pkg::STAT_NOTE_OFF: kind = mtep_pkg::KIND_NOTE_OFF;
      mtep_pkg::STAT_PROGRAM,
      mtep_pkg::STAT_PRESSURE: kind = mtep_pkg::KIND_ONE_DATA;
      default:                 kind = mtep_pkg::KIND_TWO_DATA;
    endcase
    one_data = (kind == mtep_pkg::KIND_ONE_DATA);
  end

  // Per-byte step
  always_comb begin
    phase_next      = phase_eff;
    acc_next        = acc_eff;
    run_status_next = rs_eff;
    held_next       = held_eff;
    emit            = 1'b0;
    emit_first      = data_byte;
    emit_second     = 8'h00;
    case (phase_eff)
      PH_DELTA: begin
        acc_next = DELTA_BITS'({acc_eff, data_byte[6:0]});
        if (!data_byte[7]) phase_next = PH_STATUS;
      end
      PH_STATUS: begin
        if (data_byte[7]) begin
          run_status_next = data_byte;
          phase_next      = PH_FIRST;
        end else if (rs_eff[7]) begin
          // data under running status counts as first data
          if (one_data) begin
            emit = 1'b1;
          end else begin
            held_next  = data_byte;
            phase_next = PH_SECOND;
          end
        end
        // data with no status yet is dropped
      end
      PH_FIRST: begin
        if (one_data) begin
          emit = 1'b1;
        end else begin
          held_next  = data_byte;
          phase_next = PH_SECOND;
        end
      end
      default: begin
        emit        = 1'b1;
        emit_first  = held_eff;
        emit_second = data_byte;
      end
    endcase
    if (emit) begin
      acc_next   = '0;
      phase_next = PH_DELTA;
    end
  end

  // Result word
  always_comb begin
    push               = accept && emit;
    result.kind        = kind;
    result.status_high = rs_eff[7:4];
    result.channel     = rs_eff[3:0];
    result.first_data  = emit_first;
    result.second_data = emit_second;
    result.delta_time  = mtep_pkg::DELTA_OUT_W'(acc_eff);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DELTA;
      acc        <= '0;
      run_status <= 8'h00;
      held       <= 8'h00;
    end else if (accept) begin
      phase      <= phase_next;
      acc        <= acc_next;
      run_status <= run_status_next;
      held       <= held_next;
    end
  end

  // Checks
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("result pushed without an accepted word");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    push |=> (phase == PH_DELTA) && (acc == '0))
    else $error("event did not clear delta state");

  a_status_seen: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FIRST || phase == PH_SECOND) |-> run_status[7])
    else $error("data phase without a status in force");

endmodule

`default_nettype wire

// ----- sv/mtep_out_q.sv -----
// ----------------------------------------------------------------------------
// mtep_out_q: two-entry result queue
// Output register plus skid slot, so the decoder keeps taking words while a
// result waits on a stalled consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtep_out_q (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mtep_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mtep_pkg::result_t      out_data
);

  mtep_pkg::result_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full result queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1 && pop && !push) |=> !out_valid)
    else $error("queue still valid after last word left");

endmodule

`default_nettype wire

// ----- sv/midi_track_event_parser_unit.sv -----
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit: MIDI track event parser
// Decodes track body bytes into events with delta time, status and data.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Word
// in       in   in_valid/in_stall    data_byte, track_start
// out      out  out_valid/out_stall  event_kind, status_high, channel,
//                                    first_data, second_data, delta_time
//
// One input word per cycle while in_stall is low; a result is registered
// in the queue the cycle after its final byte; older results leave first.
// The in channel stalls only when both result queue slots hold words.
// Reset (rst, synchronous) empties the queue and clears the parse state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser_unit #(
  parameter int DELTA_BITS = mtep_pkg::DELTA_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             track_start,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            event_kind,
  output logic [3:0]                            status_high,
  output logic [3:0]                            channel,
  output logic [7:0]                            first_data,
  output logic [7:0]                            second_data,
  output logic [mtep_pkg::DELTA_OUT_W-1:0]      delta_time
);

  logic              accept;
  logic              push;
  logic              full;
  mtep_pkg::result_t push_data;
  mtep_pkg::result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  mtep_decode #(
    .DELTA_BITS (DELTA_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .track_start (track_start),
    .push        (push),
    .result      (push_data)
  );

  mtep_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack result word onto the ports
  assign event_kind  = out_data.kind;
  assign status_high = out_data.status_high;
  assign channel     = out_data.channel;
  assign first_data  = out_data.first_data;
  assign second_data = out_data.second_data;
  assign delta_time  = out_data.delta_time;

endmodule

`default_nettype wire
